[design/efc_pkg.sv]
// ----------------------------------------------------------------------------
// efc_pkg
// shared types and constants for the event frame checker
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int BUFFER_WORDS_LOG2 = 20;

    localparam logic [31:0] HEADER_MAGIC  = 32'hFFFF_FAFA;
    localparam logic [31:0] TRAILER_MAGIC = 32'hFFFF_F5F5;
    localparam logic [34:0] HEADER_EXTRA  = 35'd7;
    localparam logic [20:0] COUNT_MAX     = 21'h1F_FFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_MAGIC   = 3'd1,
        STAT_BAD_LENGTH  = 3'd2,
        STAT_BAD_TRAILER = 3'd3,
        STAT_TRUNCATED   = 3'd4
    } status_t;

    typedef enum logic {
        KIND_EVENT   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        buffer_end;
        logic [7:0]  buffer_number;
    } item_t;

    typedef struct packed {
        kind_t       record_kind;
        logic [19:0] event_offset;
        logic [22:0] event_bytes;
        logic [7:0]  record_buffer;
        logic [20:0] event_count;
        status_t     status;
        logic        final_result;
    } result_t;

    typedef struct packed {
        logic    first_ok;
        result_t first;
        logic    second_ok;
        result_t second;
    } push_t;

endpackage

[design/efc_parser.sv]
// ----------------------------------------------------------------------------
// efc_parser
// input register and per-word frame parsing, emits up to two results per word
// ----------------------------------------------------------------------------
module efc_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  efc_pkg::item_t  item,
    input  logic            room,
    output efc_pkg::push_t  push
);

    logic                                   item_valid_reg;
    efc_pkg::item_t                         item_reg;
    logic                                   fire;

    logic [efc_pkg::BUFFER_WORDS_LOG2-1:0]  word_pos_reg;
    logic [efc_pkg::BUFFER_WORDS_LOG2-1:0]  word_pos_next;
    logic [31:0]                            frame_pos_reg;
    logic [31:0]                            frame_pos_next;
    logic [31:0]                            total_reg;
    logic [31:0]                            total_next;
    logic [33:0]                            sum_reg;
    logic [33:0]                            sum_next;
    logic [33:0]                            sum_add;
    logic [efc_pkg::BUFFER_WORDS_LOG2-1:0]  start_reg;
    logic [efc_pkg::BUFFER_WORDS_LOG2-1:0]  start_next;
    logic [20:0]                            count_reg;
    logic [20:0]                            count_next;
    efc_pkg::status_t                       stop_reg;
    efc_pkg::status_t                       stop_next;
    efc_pkg::status_t                       summary_status;
    logic                                   event_hit;
    efc_pkg::result_t                       event_rec;
    efc_pkg::result_t                       summary_rec;

    assign item_stall = item_valid_reg && !room;
    assign fire       = item_valid_reg && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    assign sum_add = sum_reg + {2'b00, item_reg.data_word};

    always_comb
    begin
        word_pos_next  = word_pos_reg + 1'b1;
        frame_pos_next = frame_pos_reg;
        total_next     = total_reg;
        sum_next       = sum_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        stop_next      = stop_reg;
        event_hit      = 1'b0;

        if (stop_reg == efc_pkg::STAT_OK)
        begin
            if (frame_pos_reg == 32'd0)
            begin
                if (item_reg.data_word != efc_pkg::HEADER_MAGIC)
                begin
                    stop_next = efc_pkg::STAT_BAD_MAGIC;
                end
                else
                begin
                    start_next     = word_pos_reg;
                    sum_next       = '0;
                    frame_pos_next = 32'd1;
                end
            end
            else if (frame_pos_reg == 32'd1)
            begin
                total_next     = item_reg.data_word;
                frame_pos_next = 32'd2;
            end
            else if (frame_pos_reg <= 32'd5)
            begin
                sum_next = sum_add;
                if (frame_pos_reg == 32'd5
                    && {3'b000, total_reg} != ({1'b0, sum_add} + efc_pkg::HEADER_EXTRA))
                begin
                    stop_next = efc_pkg::STAT_BAD_LENGTH;
                end
                else
                begin
                    frame_pos_next = frame_pos_reg + 32'd1;
                end
            end
            else if (frame_pos_reg == total_reg - 32'd1)
            begin
                if (item_reg.data_word != efc_pkg::TRAILER_MAGIC)
                begin
                    stop_next = efc_pkg::STAT_BAD_TRAILER;
                end
                else
                begin
                    event_hit      = 1'b1;
                    frame_pos_next = 32'd0;
                    if (count_reg < efc_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 21'd1;
                    end
                end
            end
            else
            begin
                frame_pos_next = frame_pos_reg + 32'd1;
            end
        end

        if (stop_next == efc_pkg::STAT_OK && frame_pos_next != 32'd0)
        begin
            summary_status = efc_pkg::STAT_TRUNCATED;
        end
        else
        begin
            summary_status = stop_next;
        end

        event_rec.record_kind   = efc_pkg::KIND_EVENT;
        event_rec.event_offset  = 20'(start_reg);
        event_rec.event_bytes   = {total_reg[20:0], 2'b00};
        event_rec.record_buffer = item_reg.buffer_number;
        event_rec.event_count   = count_next;
        event_rec.status        = efc_pkg::STAT_OK;
        event_rec.final_result  = !item_reg.buffer_end;

        summary_rec.record_kind   = efc_pkg::KIND_SUMMARY;
        summary_rec.event_offset  = '0;
        summary_rec.event_bytes   = '0;
        summary_rec.record_buffer = item_reg.buffer_number;
        summary_rec.event_count   = count_next;
        summary_rec.status        = summary_status;
        summary_rec.final_result  = 1'b1;

        push.first_ok  = fire && (event_hit || item_reg.buffer_end);
        push.first     = event_hit ? event_rec : summary_rec;
        push.second_ok = fire && event_hit && item_reg.buffer_end;
        push.second    = summary_rec;

        if (item_reg.buffer_end)
        begin
            word_pos_next  = '0;
            frame_pos_next = '0;
            total_next     = '0;
            sum_next       = '0;
            start_next     = '0;
            count_next     = '0;
            stop_next      = efc_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_pos_reg  <= '0;
            frame_pos_reg <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            stop_reg      <= efc_pkg::STAT_OK;
        end
        else if (fire)
        begin
            word_pos_reg  <= word_pos_next;
            frame_pos_reg <= frame_pos_next;
            total_reg     <= total_next;
            sum_reg       <= sum_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            stop_reg      <= stop_next;
        end
    end

    a_stop_code: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg == efc_pkg::STAT_OK || stop_reg == efc_pkg::STAT_BAD_MAGIC
        || stop_reg == efc_pkg::STAT_BAD_LENGTH || stop_reg == efc_pkg::STAT_BAD_TRAILER)
        else $error("parser stop status holds a code that cannot stop parsing");

    a_buffer_reset: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.buffer_end |=>
        stop_reg == efc_pkg::STAT_OK && frame_pos_reg == 32'd0 && word_pos_reg == '0
        && count_reg == 21'd0)
        else $error("parser state not cleared after the end of a buffer");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_ok |-> push.first_ok && push.first.record_kind == efc_pkg::KIND_EVENT
        && push.second.record_kind == efc_pkg::KIND_SUMMARY)
        else $error("two results from one word out of order");

endmodule

[design/efc_out_queue.sv]
// ----------------------------------------------------------------------------
// efc_out_queue
// small result queue, takes up to two results a cycle and gives out one while not stalled
// ----------------------------------------------------------------------------
module efc_out_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  efc_pkg::push_t    push,
    output logic              room,
    output logic              result_valid,
    input  logic              result_stall,
    output efc_pkg::result_t  result
);

    efc_pkg::result_t                  mem_reg [efc_pkg::QUEUE_DEPTH];
    logic [efc_pkg::QUEUE_IDX_W-1:0]   head_reg;
    logic [efc_pkg::QUEUE_IDX_W-1:0]   tail_reg;
    logic [efc_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [efc_pkg::QUEUE_CNT_W-1:0]   count_next;
    logic [efc_pkg::QUEUE_CNT_W-1:0]   push_cnt;
    logic                              pop;

    assign room         = count_reg <= efc_pkg::QUEUE_CNT_W'(efc_pkg::QUEUE_DEPTH - 2);
    assign result_valid = count_reg != '0;
    assign result       = mem_reg[head_reg];
    assign pop          = result_valid && !result_stall;
    assign push_cnt     = efc_pkg::QUEUE_CNT_W'(push.first_ok)
                        + efc_pkg::QUEUE_CNT_W'(push.second_ok);
    assign count_next   = count_reg + push_cnt - efc_pkg::QUEUE_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.first_ok)
        begin
            mem_reg[tail_reg] <= push.first;
        end
        if (push.second_ok)
        begin
            mem_reg[tail_reg + 1'b1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_reg + efc_pkg::QUEUE_IDX_W'(pop);
            tail_reg  <= tail_reg + efc_pkg::QUEUE_IDX_W'(push_cnt);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= efc_pkg::QUEUE_CNT_W'(efc_pkg::QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != '0 |-> room)
        else $error("result pushed without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> count_reg == $past(count_reg) + $past(push_cnt)
        - efc_pkg::QUEUE_CNT_W'($past(pop)))
        else $error("result queue count lost track");

endmodule

[design/event_frame_checker.sv]
// ----------------------------------------------------------------------------
// event_frame_checker
// splits a readout buffer into event frames and reports events and a summary
// ----------------------------------------------------------------------------
// One buffer word is taken per cycle while the result queue has room; a taken
// word is held in the input register and its results are written from there
// into the result queue, whose head is the output. A word gives at most two
// results (an event record, then the end-of-buffer summary), sent out one per
// cycle while the output is not stalled, from a four-entry result queue; the
// input stalls only while that queue holds more than two results.
// ----------------------------------------------------------------------------
module event_frame_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  efc_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output efc_pkg::result_t  result
);

    efc_pkg::push_t  push;
    logic            room;

    efc_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .room       (room),
        .push       (push)
    );

    efc_out_queue u_out_queue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
